// File: src/efot_pkg.sv
// package for the epoch fenced ownership table
// holds sizes, codes and the request and result beat structs; no dependencies
package efot_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned EpochBits = 32;
  localparam int unsigned TagBits   = 16;
  localparam int unsigned IdxBits   = $clog2(Entries);

  typedef enum logic [2:0] {
    FUNC_LOAD    = 3'd0,
    FUNC_PARK    = 3'd1,
    FUNC_REPLY   = 3'd2,
    FUNC_RELEASE = 3'd3,
    FUNC_DROPALL = 3'd4,
    FUNC_QUERY   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    PH_LOADING = 2'd0,
    PH_ACTIVE  = 2'd1,
    PH_PARKING = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_TAKEOVER = 2'd1,
    KIND_PARK     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OUT_NONE     = 3'd0,
    OUT_STALE    = 3'd1,
    OUT_REJECTED = 3'd2,
    OUT_LOADED   = 3'd3,
    OUT_PARKED   = 3'd4,
    OUT_IGNORED  = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] root_id;
    logic [31:0] epoch;
    logic        takeover;
    logic [31:0] checkpoint;
    logic [15:0] tag;
    logic        reply_ok;
    logic        reply_op;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        req_valid;
    logic [1:0]  req_kind;
    logic [31:0] req_epoch;
    logic [15:0] req_tag;
    logic        found;
    logic [1:0]  local_state;
    logic [31:0] entry_epoch;
    logic        authoritative;
    logic        gate_open;
    logic [2:0]  outcome;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [31:0]          root;
    logic [1:0]           phase;
    logic [EpochBits-1:0] epoch;
    logic [TagBits-1:0]   inc;
    logic [1:0]           infl;
  } entry_t;

  // lookup result handed from the match stage to the update logic
  typedef struct packed {
    logic               hit;
    logic [IdxBits-1:0] hit_idx;
    logic               has_free;
    logic [IdxBits-1:0] free_idx;
  } lookup_t;

endpackage

// File: src/efot_match.sv
// parallel key compare and lowest-free search over the entry table
// depends on efot_pkg
module efot_match import efot_pkg::*; (
  input  logic [Entries-1:0] used_i,
  input  entry_t             ent_i [Entries],
  input  logic [31:0]        root_i,
  output lookup_t            lk_o
);

  // priority search, at most one key can hit
  always_comb begin
    lk_o = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (used_i[i] && ent_i[i].root == root_i && root_i != '0) begin
        lk_o.hit     = 1'b1;
        lk_o.hit_idx = IdxBits'(i);
      end
      if (!used_i[i]) begin
        lk_o.has_free = 1'b1;
        lk_o.free_idx = IdxBits'(i);
      end
    end
  end

endmodule

// File: src/epoch_fenced_ownership_table_unit.sv
// top level of the epoch fenced ownership table
// depends on efot_pkg and efot_match
//
// usage:
//   raise start with a command beat on cmd_i; it is taken at that edge
//   since busy is always low, so one command can enter every cycle.
//   each command yields exactly one result beat on rsp_o, marked by
//   done_o, in the cycle after acceptance.
//   the table lookup is a parallel compare across all entries in the
//   cycle of acceptance; table and counters update at that same edge,
//   so back-to-back commands see each other's effects.
//   reset clears the used bits, the incarnation counter and the drop
//   floor; entry contents are only read while in use.
//   the receiver cannot stall: a result is on rsp_o for one cycle only.
module epoch_fenced_ownership_table_unit import efot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t cmd_i,
  output logic done_o,
  output rsp_t rsp_o
);

  logic [Entries-1:0] used_q, used_d;
  entry_t             ent_q [Entries];
  entry_t             wr_ent;
  logic               wr_en;
  logic [IdxBits-1:0] wr_idx;
  logic [TagBits-1:0] ninc_q, ninc_d, floor_q, floor_d;
  rsp_t               rsp_d;
  logic               done_d;
  lookup_t            lk;
  entry_t             cur;
  logic [TagBits-1:0] tag, since, issued;
  logic [EpochBits-1:0] ep, ours;
  logic               take;

  assign busy = 1'b0;
  assign take = start && !busy;
  assign tag  = cmd_i.tag[TagBits-1:0];
  assign ep   = cmd_i.epoch[EpochBits-1:0];

  efot_match u_match (
    .used_i (used_q),
    .ent_i  (ent_q),
    .root_i (cmd_i.root_id),
    .lk_o   (lk)
  );

  assign cur = ent_q[lk.hit_idx];

  // command decode and table update
  always_comb begin
    used_d = used_q;
    ninc_d = ninc_q;
    floor_d = floor_q;
    rsp_d  = '0;
    wr_en  = 1'b0;
    wr_idx = lk.hit_idx;
    wr_ent = cur;
    since  = tag - floor_q;
    issued = ninc_q - floor_q;
    ours   = cur.epoch;
    if (take) begin
      case (cmd_i.func)
        FUNC_LOAD: begin
          if (cmd_i.root_id != '0 && !lk.hit && lk.has_free) begin
            ninc_d = ninc_q + 1'b1;
            used_d[lk.free_idx] = 1'b1;
            wr_en  = 1'b1;
            wr_idx = lk.free_idx;
            wr_ent = '{root: cmd_i.root_id, phase: PH_LOADING, epoch: ep,
                       inc: ninc_d, infl: 2'd1};
            rsp_d.accepted  = 1'b1;
            rsp_d.req_valid = 1'b1;
            rsp_d.req_kind  = cmd_i.takeover ? KIND_TAKEOVER : KIND_LOAD;
            rsp_d.req_epoch = 32'(ep);
            rsp_d.req_tag   = 16'(ninc_d);
          end
        end
        FUNC_PARK: begin
          if (lk.hit && cur.phase == PH_ACTIVE) begin
            wr_en = 1'b1;
            wr_ent.phase = PH_PARKING;
            if (cur.infl != 2'd3) wr_ent.infl = cur.infl + 2'd1;
            rsp_d.accepted  = 1'b1;
            rsp_d.req_valid = 1'b1;
            rsp_d.req_kind  = KIND_PARK;
            rsp_d.req_epoch = 32'(cur.epoch);
            rsp_d.req_tag   = 16'(cur.inc);
          end
        end
        FUNC_REPLY: begin
          if (since == '0 || since > issued) begin
            rsp_d.outcome = OUT_IGNORED;
          end else if (!lk.hit || cur.inc != tag) begin
            rsp_d.outcome = OUT_STALE;
          end else begin
            wr_en = 1'b1;
            if (cur.infl != 2'd0) wr_ent.infl = cur.infl - 2'd1;
            if (!cmd_i.reply_ok) begin
              used_d[lk.hit_idx] = 1'b0;
              rsp_d.outcome = OUT_REJECTED;
            end else if (!cmd_i.reply_op) begin
              wr_ent.epoch = ep;
              if (cur.phase == PH_LOADING) wr_ent.phase = PH_ACTIVE;
              rsp_d.outcome = OUT_LOADED;
            end else begin
              used_d[lk.hit_idx] = 1'b0;
              rsp_d.outcome = OUT_PARKED;
            end
          end
        end
        FUNC_RELEASE: begin
          if (cur.phase == PH_LOADING && cur.epoch != '1) ours = cur.epoch + 1'b1;
          if (lk.hit && ours < ep) begin
            used_d[lk.hit_idx] = 1'b0;
            rsp_d.accepted = 1'b1;
          end
        end
        FUNC_DROPALL: begin
          used_d  = '0;
          floor_d = ninc_q;
        end
        FUNC_QUERY: begin
          if (lk.hit) begin
            rsp_d.found         = 1'b1;
            rsp_d.local_state   = cur.phase;
            rsp_d.entry_epoch   = 32'(cur.epoch);
            rsp_d.authoritative = cur.phase == PH_ACTIVE;
            rsp_d.gate_open     = cur.phase == PH_ACTIVE && cur.infl == 2'd0;
          end
        end
        default: begin
        end
      endcase
    end
    done_d = take;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      ninc_q  <= '0;
      floor_q <= '0;
      done_o  <= 1'b0;
    end else begin
      used_q  <= used_d;
      ninc_q  <= ninc_d;
      floor_q <= floor_d;
      done_o  <= done_d;
    end
  end

  // entry payload and result register
  always_ff @(posedge clk_i) begin
    if (wr_en) ent_q[wr_idx] <= wr_ent;
    rsp_o <= rsp_d;
  end

  // every accepted beat yields a result beat on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> done_o)
    else $error("missing result beat");
  // a load takes one new incarnation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cmd_i.func == FUNC_LOAD && rsp_d.accepted |=> ninc_q == $past(ninc_q) + 1'b1)
    else $error("incarnation did not advance on load");
  // drop all empties the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cmd_i.func == FUNC_DROPALL |=> used_q == '0 && floor_q == $past(ninc_q))
    else $error("drop all left entries");

endmodule

// File: test/tb_epoch_fenced_ownership_table_unit.sv
// testbench for the epoch fenced ownership table
// depends on efot_pkg and epoch_fenced_ownership_table_unit; self-checking
module tb_epoch_fenced_ownership_table_unit;
  import efot_pkg::*;

  localparam int unsigned MaxCycles = 200000;

  // behavioral copy of the table with an expected-result queue
  class own_table_sb;
    bit          used [Entries];
    logic [31:0] root [Entries];
    phase_e      phase [Entries];
    logic [31:0] ep [Entries];
    logic [15:0] inc [Entries];
    logic [1:0]  infl [Entries];
    logic [15:0] next_inc;
    logic [15:0] floor_inc;
    rsp_t        pending_rsp [$];
    int          n_err;
    int          n_checked;

    function new();
      for (int i = 0; i < Entries; i++) used[i] = 0;
      next_inc = '0;
      floor_inc = '0;
      n_err = 0;
      n_checked = 0;
    endfunction

    function int lookup(logic [31:0] r);
      if (r == 0) return -1;
      for (int i = 0; i < Entries; i++) if (used[i] && root[i] == r) return i;
      return -1;
    endfunction

    function int occupied();
      int n;
      n = 0;
      for (int i = 0; i < Entries; i++) n += used[i];
      return n;
    endfunction

    // apply one accepted command and queue its result
    function void note_cmd(req_t c);
      rsp_t        r;
      int          idx;
      int          fr;
      logic [15:0] since;
      logic [15:0] issued;
      logic [32:0] ours;
      r = '0;
      idx = lookup(c.root_id);
      case (c.func)
        FUNC_LOAD: begin
          fr = -1;
          for (int i = Entries - 1; i >= 0; i--) if (!used[i]) fr = i;
          if (c.root_id != 0 && idx < 0 && fr >= 0) begin
            next_inc = next_inc + 16'd1;
            used[fr] = 1;
            root[fr] = c.root_id;
            phase[fr] = PH_LOADING;
            ep[fr] = c.epoch;
            inc[fr] = next_inc;
            infl[fr] = 2'd1;
            r.accepted = 1;
            r.req_valid = 1;
            r.req_kind = c.takeover ? KIND_TAKEOVER : KIND_LOAD;
            r.req_epoch = c.epoch;
            r.req_tag = next_inc;
          end
        end
        FUNC_PARK: begin
          if (idx >= 0 && phase[idx] == PH_ACTIVE) begin
            phase[idx] = PH_PARKING;
            if (infl[idx] != 2'd3) infl[idx]++;
            r.accepted = 1;
            r.req_valid = 1;
            r.req_kind = KIND_PARK;
            r.req_epoch = ep[idx];
            r.req_tag = inc[idx];
          end
        end
        FUNC_REPLY: begin
          since = c.tag - floor_inc;
          issued = next_inc - floor_inc;
          if (since == 0 || since > issued) r.outcome = OUT_IGNORED;
          else if (idx < 0 || inc[idx] != c.tag) r.outcome = OUT_STALE;
          else begin
            if (infl[idx] != 0) infl[idx]--;
            if (!c.reply_ok) begin
              used[idx] = 0;
              r.outcome = OUT_REJECTED;
            end else if (c.reply_op == 1'b0) begin
              ep[idx] = c.epoch;
              if (phase[idx] == PH_LOADING) phase[idx] = PH_ACTIVE;
              r.outcome = OUT_LOADED;
            end else begin
              used[idx] = 0;
              r.outcome = OUT_PARKED;
            end
          end
        end
        FUNC_RELEASE: begin
          if (idx >= 0) begin
            ours = {1'b0, ep[idx]};
            if (phase[idx] == PH_LOADING && ep[idx] != 32'hffff_ffff) ours++;
            if (ours < {1'b0, c.epoch}) begin
              used[idx] = 0;
              r.accepted = 1;
            end
          end
        end
        FUNC_DROPALL: begin
          for (int i = 0; i < Entries; i++) used[i] = 0;
          floor_inc = next_inc;
        end
        FUNC_QUERY: begin
          if (idx >= 0) begin
            r.found = 1;
            r.local_state = phase[idx];
            r.entry_epoch = ep[idx];
            r.authoritative = (phase[idx] == PH_ACTIVE);
            r.gate_open = (phase[idx] == PH_ACTIVE) && (infl[idx] == 0);
          end
        end
        default: ;
      endcase
      pending_rsp = {pending_rsp, r};
    endfunction

    function void fail(string what, rsp_t want, rsp_t got);
      n_err++;
      if (n_err <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
    endfunction

    // compare one result beat against the oldest expectation
    function void check_rsp(rsp_t got);
      rsp_t w;
      if (pending_rsp.size() == 0) begin
        fail("unexpected beat", '0, got);
        return;
      end
      w = pending_rsp.pop_front();
      n_checked++;
      if (got.accepted !== w.accepted) fail("accepted", w, got);
      if (got.req_valid !== w.req_valid) fail("req_valid", w, got);
      if (got.req_kind !== w.req_kind) fail("req_kind", w, got);
      if (got.req_epoch !== w.req_epoch) fail("req_epoch", w, got);
      if (got.req_tag !== w.req_tag) fail("req_tag", w, got);
      if (got.found !== w.found) fail("found", w, got);
      if (got.local_state !== w.local_state) fail("local_state", w, got);
      if (got.entry_epoch !== w.entry_epoch) fail("entry_epoch", w, got);
      if (got.authoritative !== w.authoritative) fail("authoritative", w, got);
      if (got.gate_open !== w.gate_open) fail("gate_open", w, got);
      if (got.outcome !== w.outcome) fail("outcome", w, got);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  req_t cmd_i = '0;
  logic done_o;
  rsp_t rsp_o;

  own_table_sb sb;
  int          cycle_cnt = 0;
  bit          quiet_mode = 0;
  logic [31:0] root_pool [8];
  logic [15:0] tags_seen [$];

  epoch_fenced_ownership_table_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // note accepted commands and check result beats at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_rsp(rsp_o);
      if (start && !busy) begin
        sb.note_cmd(cmd_i);
        if (cmd_i.func == FUNC_LOAD || cmd_i.func == FUNC_PARK)
          tags_seen = {tags_seen, sb.next_inc};
        if (tags_seen.size() > 32) void'(tags_seen.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  // send one command beat and hold it until taken
  task automatic send_cmd(req_t c);
    if (!quiet_mode && $urandom_range(0, 99) < 8) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start <= 1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_until_drained();
    start <= 0;
    do @(negedge clk_i); while (sb.pending_rsp.size() != 0);
  endtask

  function automatic req_t mk(func_e f, logic [31:0] r, logic [31:0] e);
    req_t c;
    c = '0;
    c.func = f;
    c.root_id = r;
    c.epoch = e;
    c.checkpoint = $urandom();
    return c;
  endfunction

  function automatic req_t reply(logic [31:0] r, logic [15:0] t, bit ok, bit op,
                                 logic [31:0] e);
    req_t c;
    c = mk(FUNC_REPLY, r, e);
    c.tag = t;
    c.reply_ok = ok;
    c.reply_op = op;
    return c;
  endfunction

  // random command biased toward well-formed load/reply/park sequences
  function automatic req_t rand_cmd();
    req_t        c;
    int          sel;
    int          idx;
    logic [31:0] r;
    sel = $urandom_range(0, 99);
    r = root_pool[$urandom_range(0, 7)];
    idx = sb.lookup(r);
    if (sel < 25) begin
      c = mk(FUNC_LOAD, r, $urandom());
      c.takeover = $urandom_range(0, 1);
      if ($urandom_range(0, 19) == 0) c.root_id = $urandom_range(0, 1) ? 0 : $urandom();
    end else if (sel < 50) begin
      if (idx >= 0 && $urandom_range(0, 9) != 0)
        c = reply(r, sb.inc[idx], $urandom_range(0, 9) != 0,
                  sb.phase[idx] == PH_PARKING, $urandom());
      else if (tags_seen.size() != 0 && $urandom_range(0, 1))
        c = reply(r, tags_seen[$urandom_range(0, tags_seen.size() - 1)],
                  $urandom_range(0, 1), $urandom_range(0, 1), $urandom());
      else
        c = reply(r, 16'($urandom()), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom());
    end else if (sel < 65) begin
      c = mk(FUNC_PARK, r, $urandom());
    end else if (sel < 75) begin
      c = mk(FUNC_RELEASE, r, (idx >= 0 && $urandom_range(0, 1)) ?
             sb.ep[idx] + $urandom_range(0, 2) - 1 : $urandom());
    end else if (sel < 77) begin
      c = mk(FUNC_DROPALL, $urandom(), $urandom());
    end else if (sel < 97) begin
      c = mk(FUNC_QUERY, r, $urandom());
    end else begin
      c = mk(func_e'($urandom_range(6, 7)), $urandom(), $urandom());
    end
    c.checkpoint = $urandom();
    if ($urandom_range(0, 3) == 0) c.takeover = $urandom_range(0, 1);
    return c;
  endfunction

  initial begin
    req_t c;
    sb = new();
    for (int i = 0; i < 8; i++) root_pool[i] = (i == 7) ? 32'hffff_ffff : $urandom() | 1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: refusals, full table, replies, park, release edges, drop-all
    send_cmd(mk(FUNC_LOAD, 32'd0, 32'd5));
    c = mk(FUNC_LOAD, 32'hffff_ffff, 32'hffff_ffff);
    c.takeover = 1;
    send_cmd(c);
    send_cmd(mk(FUNC_LOAD, 32'hffff_ffff, 32'd1));
    send_cmd(mk(FUNC_RELEASE, 32'hffff_ffff, 32'hffff_ffff));
    send_cmd(mk(FUNC_QUERY, 32'hffff_ffff, 32'd0));
    for (int i = 1; i <= Entries; i++) send_cmd(mk(FUNC_LOAD, i, i));
    send_cmd(reply(32'd1, 16'd2, 1, 0, 32'd0));
    send_cmd(reply(32'd1, 16'hffff, 1, 0, 32'd0));
    send_cmd(mk(FUNC_PARK, 32'd2, 32'd0));
    send_cmd(reply(32'd2, 16'd3, 1, 0, 32'd77));
    send_cmd(mk(FUNC_QUERY, 32'd2, 32'd0));
    send_cmd(mk(FUNC_PARK, 32'd2, 32'd0));
    send_cmd(reply(32'd2, 16'd3, 1, 1, 32'd0));
    send_cmd(reply(32'd3, 16'd4, 0, 0, 32'd0));
    send_cmd(mk(FUNC_RELEASE, 32'd5, 32'd7));
    send_cmd(mk(FUNC_DROPALL, 32'd0, 32'd0));
    send_cmd(reply(32'd6, 16'd7, 1, 0, 32'd0));
    send_cmd(mk(func_e'(3'd7), 32'd9, 32'd9));
    idle_until_drained();

    // random phase, with an idle-free stretch and a drain pause
    for (int i = 0; i < 1900; i++) begin
      quiet_mode = (i >= 600 && i < 900);
      if (i == 1200) idle_until_drained();
      send_cmd(rand_cmd());
    end
    idle_until_drained();
    repeat (5) @(negedge clk_i);

    $display("ran directed cases and 1900 random commands");
    $display("%0d results checked, %0d mismatches", sb.n_checked, sb.n_err);
    if (sb.n_err == 0 && sb.pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
